// ===== hdl/sha_pkg.sv =====
package sha_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam int unsigned HASH_WORDS  = 8;
    localparam int unsigned ROUNDS      = 64;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_word message_word;
        logic  first_block;
        logic  final_block;
    } t_in_item;

    typedef struct packed {
        t_word       digest_word;
        logic [2:0]  word_index;
        logic        last;
    } t_out_item;

    // controller to datapath commands
    typedef struct packed {
        logic        load_word;   // shift an accepted word into the window
        logic        start;       // 16th word: set up the working variables
        logic        first;       // with start: take the initial hash
        logic        round_en;    // run one round
        logic [5:0]  round_idx;   // round number for the constant lookup
        logic        add_en;      // fold working variables into chaining value
        logic        out_load;    // capture one digest word
        logic [2:0]  out_idx;     // which digest word
    } t_cmd;

    localparam t_word INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam t_word ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic t_word rotr(input t_word x, input int unsigned n);
        rotr = (x >> n) | (x << (WORD_W - n));
    endfunction

    function automatic t_word big_sigma0(input t_word x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic t_word big_sigma1(input t_word x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic t_word small_sigma0(input t_word x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic t_word small_sigma1(input t_word x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

// ===== hdl/sha256_block_compress_core.sv =====
// sha-256 compression core: 16 words in per padded block, one word per cycle while o_in_stall is low
// after the 16th word transfer: the rounds, then the chaining add, then for a
// final block the eight digest words leave one per cycle from an output register unless stalled
// the input stalls until a block is done, so a new block waits for the single shared
// round unit, which runs one round per cycle
// reset (synchronous, active low): chaining value zero, word counter zero, idle
module sha256_block_compress_core
    import sha_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input channel: one message word per transfer
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    // output channel: one digest word per transfer
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    t_cmd       cmd;
    t_word      digest;
    logic [2:0] out_idx;
    logic       out_last;

    // controller: word count, round count, output sequencing
    sha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_first     (i_in_data.first_block),
        .i_final     (i_in_data.final_block),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_idx   (out_idx),
        .o_out_last  (out_last),
        .o_cmd       (cmd)
    );

    // datapath: schedule window, working variables, chaining value
    sha_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_word   (i_in_data.message_word),
        .o_digest (digest)
    );

    // digest word, index and last flag are all registered and held while stalled
    assign o_out_data.digest_word = digest;
    assign o_out_data.word_index  = out_idx;
    assign o_out_data.last        = out_last;

endmodule

// ===== hdl/sha_ctrl.sv =====
module sha_ctrl
    import sha_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_first,
    input  logic       i_final,
    input  logic       i_out_stall,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output logic [2:0] o_out_idx,
    output logic       o_out_last,
    output t_cmd       o_cmd
);

    typedef enum logic [1:0] {
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_OUT
    } t_state;

    t_state     r_state;
    logic [3:0] r_words;
    logic [5:0] r_round;
    logic       r_final;
    logic [2:0] r_emit;
    logic       r_out_valid;
    logic [2:0] r_out_idx;
    logic       r_out_last;

    logic in_xfer;

    assign o_in_stall = (r_state != S_LOAD);
    assign in_xfer    = i_in_valid && (r_state == S_LOAD);

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_word = in_xfer;
        o_cmd.start     = in_xfer && (r_words == 4'(BLOCK_WORDS - 1));
        o_cmd.first     = i_first;
        o_cmd.round_en  = (r_state == S_ROUND);
        o_cmd.round_idx = r_round;
        o_cmd.add_en    = (r_state == S_ADD);
        o_cmd.out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);
        o_cmd.out_idx   = r_emit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_words     <= '0;
            r_round     <= '0;
            r_final     <= 1'b0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
            r_out_idx   <= '0;
            r_out_last  <= 1'b0;
        end else begin
            unique case (r_state)
                S_LOAD: begin
                    if (in_xfer) begin
                        r_words <= r_words + 4'd1;
                        if (o_cmd.start) begin
                            r_final <= i_final;
                            r_round <= '0;
                            r_state <= S_ROUND;
                        end
                    end
                end
                S_ROUND: begin
                    r_round <= r_round + 6'd1;
                    if (r_round == 6'(ROUNDS - 1)) begin
                        r_state <= S_ADD;
                    end
                end
                S_ADD: begin
                    r_emit  <= '0;
                    r_state <= r_final ? S_OUT : S_LOAD;
                end
                S_OUT: begin
                    if (o_cmd.out_load) begin
                        r_emit <= r_emit + 3'd1;
                        if (r_emit == 3'(HASH_WORDS - 1)) begin
                            r_state <= S_LOAD;
                        end
                    end
                end
                default: r_state <= S_LOAD;
            endcase

            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_out_idx   <= r_emit;
                r_out_last  <= (r_emit == 3'(HASH_WORDS - 1));
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_idx   = r_out_idx;
    assign o_out_last  = r_out_last;

endmodule

// ===== hdl/sha_dp.sv =====
module sha_dp
    import sha_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_cmd  i_cmd,
    input  t_word i_word,
    output t_word o_digest
);

    t_word r_w  [BLOCK_WORDS];
    t_word r_v  [HASH_WORDS];
    t_word r_cv [HASH_WORDS];
    t_word r_digest;

    t_word sched_next;
    t_word sum_t1;
    t_word sum_t2;
    t_word ch;
    t_word maj;
    t_word base_cv [HASH_WORDS];

    // window holds w[t..t+15]; the round always consumes entry 0
    assign sched_next = small_sigma1(r_w[14]) + r_w[9] + small_sigma0(r_w[1]) + r_w[0];

    assign ch     = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign maj    = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign sum_t1 = r_v[7] + big_sigma1(r_v[4]) + ch + ROUND_K[i_cmd.round_idx] + r_w[0];
    assign sum_t2 = big_sigma0(r_v[0]) + maj;

    always_comb begin
        for (int i = 0; i < HASH_WORDS; i++) begin
            base_cv[i] = i_cmd.first ? INIT_HASH[i] : r_cv[i];
        end
    end

    // schedule window and digest capture, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word || i_cmd.round_en) begin
            for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[BLOCK_WORDS-1] <= i_cmd.load_word ? i_word : sched_next;
        end
        if (i_cmd.out_load) begin
            r_digest <= r_cv[i_cmd.out_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < HASH_WORDS; i++) begin
                r_v[i]  <= '0;
                r_cv[i] <= '0;
            end
        end else begin
            if (i_cmd.start) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    r_v[i]  <= base_cv[i];
                    r_cv[i] <= base_cv[i];
                end
            end else if (i_cmd.round_en) begin
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + sum_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= sum_t1 + sum_t2;
            end else if (i_cmd.add_en) begin
                for (int i = 0; i < HASH_WORDS; i++) begin
                    r_cv[i] <= r_cv[i] + r_v[i];
                end
            end
        end
    end

    assign o_digest = r_digest;

endmodule
